@@ src/sha1_hash_engine_defines.svh @@
// ----------------------------------------------------------------------------
// SHA-1 hash engine assertion macros
// Shared property forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef SHA1_HASH_ENGINE_DEFINES_SVH
`define SHA1_HASH_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SHA1_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define SHA1_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/sha1_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-1 package
// Constants, round keys and control structs shared by the engine modules.
// ----------------------------------------------------------------------------
package sha1_pkg;

    localparam int WORD_W       = 32;
    localparam int DIGEST_WORDS = 5;
    localparam int BLOCK_WORDS  = 16;
    localparam int ROUND_COUNT  = 80;
    localparam int IDX_W        = 3;
    localparam int FILL_W       = 4;
    localparam int LEN_W        = 64;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [IDX_W-1:0]  word_idx_t;

    // Initial chaining values h0..h4
    localparam word_t H_INIT [DIGEST_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    // Round constants, one per group of twenty rounds
    localparam word_t K_ROUND0 = 32'h5A827999;
    localparam word_t K_ROUND1 = 32'h6ED9EBA1;
    localparam word_t K_ROUND2 = 32'h8F1BBCDC;
    localparam word_t K_ROUND3 = 32'hCA62C1D6;

    // Padding marker for a word that opens with the 0x80 byte
    localparam word_t PAD_MARK = 32'h80000000;

    localparam logic [2:0]      FULL_BYTES    = 3'd4;
    localparam word_idx_t       LAST_WORD_IDX = word_idx_t'(DIGEST_WORDS - 1);
    localparam logic [FILL_W-1:0] LEN_HI_SLOT = FILL_W'(BLOCK_WORDS - 2);
    localparam logic [FILL_W-1:0] LAST_SLOT   = FILL_W'(BLOCK_WORDS - 1);

    // Sequencer to compression unit
    typedef struct packed {
        logic  shift;   // push word into the schedule window
        word_t word;
        logic  start;   // begin compressing the window
        logic  init;    // restore initial chaining values
    } sha1_ctrl_t;

    // Compression unit to sequencer
    typedef struct packed {
        logic busy;
    } sha1_stat_t;

endpackage

@@ src/sha1_core.sv @@
// ----------------------------------------------------------------------------
// SHA-1 compression unit
// Holds the 16-word schedule window and the chaining words, and runs one
// round per cycle through a shared round datapath, then one chaining add.
// ----------------------------------------------------------------------------
module sha1_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sha1_pkg::sha1_ctrl_t ctrl,
    output sha1_pkg::sha1_stat_t stat,
    input  sha1_pkg::word_idx_t  rd_idx,
    output sha1_pkg::word_t      rd_word
);
    import sha1_pkg::*;

    localparam int RND_W = $clog2(ROUND_COUNT + 1);
    localparam logic [RND_W-1:0] ADD_STEP = RND_W'(ROUND_COUNT);

    word_t            win_reg   [BLOCK_WORDS];
    word_t            win_next  [BLOCK_WORDS];
    word_t            chain_reg [DIGEST_WORDS];
    word_t            chain_next[DIGEST_WORDS];
    word_t            a_reg, b_reg, c_reg, d_reg, e_reg;
    word_t            a_next, b_next, c_next, d_next, e_next;
    logic [RND_W-1:0] round_reg, round_next;
    logic             busy_reg, busy_next;

    word_t f_val;
    word_t k_val;
    word_t t_val;
    word_t x_val;

    // Round function and key for the current round
    always_comb begin
        if (round_reg < RND_W'(20)) begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K_ROUND0;
        end else if (round_reg < RND_W'(40)) begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_ROUND1;
        end else if (round_reg < RND_W'(60)) begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K_ROUND2;
        end else begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_ROUND3;
        end
        t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + win_reg[0];
        x_val = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
    end

    // Window, working variables, round counter and chaining words
    always_comb begin
        win_next   = win_reg;
        chain_next = chain_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        e_next     = e_reg;
        round_next = round_reg;
        busy_next  = busy_reg;

        if (busy_reg) begin
            if (round_reg == ADD_STEP) begin
                // Fold the working variables into the chain
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                chain_next[4] = chain_reg[4] + e_reg;
                busy_next     = 1'b0;
            end else begin
                // One round, and slide the window by one expanded word
                for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                    win_next[i] = win_reg[i+1];
                end
                win_next[BLOCK_WORDS-1] = {x_val[30:0], x_val[31]};
                a_next     = t_val;
                b_next     = a_reg;
                c_next     = {b_reg[1:0], b_reg[31:2]};
                d_next     = c_reg;
                e_next     = d_reg;
                round_next = round_reg + RND_W'(1);
            end
        end else begin
            if (ctrl.shift) begin
                for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                    win_next[i] = win_reg[i+1];
                end
                win_next[BLOCK_WORDS-1] = ctrl.word;
            end
            if (ctrl.start) begin
                a_next     = chain_reg[0];
                b_next     = chain_reg[1];
                c_next     = chain_reg[2];
                d_next     = chain_reg[3];
                e_next     = chain_reg[4];
                round_next = '0;
                busy_next  = 1'b1;
            end
        end

        if (ctrl.init) begin
            chain_next = H_INIT;
        end
    end

    // Control and chaining state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            round_reg <= '0;
            chain_reg <= H_INIT;
        end else begin
            busy_reg  <= busy_next;
            round_reg <= round_next;
            chain_reg <= chain_next;
        end
    end

    // Datapath registers, no reset
    always_ff @(posedge aclk) begin
        win_reg <= win_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        d_reg   <= d_next;
        e_reg   <= e_next;
    end

    assign stat.busy = busy_reg;

    // Digest word read-out
    always_comb begin
        case (rd_idx)
            3'd0:    rd_word = chain_reg[0];
            3'd1:    rd_word = chain_reg[1];
            3'd2:    rd_word = chain_reg[2];
            3'd3:    rd_word = chain_reg[3];
            default: rd_word = chain_reg[4];
        endcase
    end

endmodule

@@ src/sha1_hash_engine.sv @@
// ----------------------------------------------------------------------------
// SHA-1 hash engine
// Collects message words, pads the tail with the marker and bit length, and
// emits the five digest words after the last block.
// ----------------------------------------------------------------------------
//  channel | ports                                    | direction
//  --------+------------------------------------------+----------
//  s_      | s_data, s_byte_count, s_final_req        | in
//  m_      | m_digest_word, m_word_index, m_last_word | out
//
//  A word is taken while the round unit is idle; the word that fills a block
//  starts the 80 rounds plus the chaining add in the round unit, and no word
//  is taken until they are done.
//  A final item adds up to 18 padding shifts and one or two compressions,
//  then five output transfers. No input is taken until the last is done.
//  aresetn (synchronous) restores h0..h4 and clears length and fill count.
//  A stalled m_ready holds the current digest word.
// ----------------------------------------------------------------------------
module sha1_hash_engine (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [31:0]              s_data,
    input  logic [2:0]               s_byte_count,
    input  logic                     s_final_req,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [31:0]              m_digest_word,
    output logic [2:0]               m_word_index,
    output logic                     m_last_word
);
    import sha1_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_PAD    = 4'b0010,
        S_FINISH = 4'b0100,
        S_OUT    = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    word_t              pad_word_reg, pad_word_next;
    logic               pad_pend_reg, pad_pend_next;
    logic               len_hi_done_reg, len_hi_done_next;
    word_idx_t          out_idx_reg, out_idx_next;

    sha1_ctrl_t ctrl;
    sha1_stat_t stat;
    word_t      rd_word;
    logic       accept;
    logic [2:0] bc_eff;
    word_t      tail_word;

    sha1_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .stat    (stat),
        .rd_idx  (out_idx_reg),
        .rd_word (rd_word)
    );

    assign s_ready = (state_reg == S_IDLE) && !stat.busy;
    assign accept  = s_valid && s_ready;

    // Clamp the byte count and build the marker word for a short tail
    always_comb begin
        bc_eff = (s_byte_count > FULL_BYTES) ? FULL_BYTES : s_byte_count;
        case (bc_eff)
            3'd0:    tail_word = PAD_MARK;
            3'd1:    tail_word = {s_data[31:24], 24'h800000};
            3'd2:    tail_word = {s_data[31:16], 16'h8000};
            3'd3:    tail_word = {s_data[31:8], 8'h80};
            default: tail_word = PAD_MARK;
        endcase
    end

    // Sequencer
    always_comb begin
        state_next       = state_reg;
        fill_next        = fill_reg;
        len_next         = len_reg;
        pad_word_next    = pad_word_reg;
        pad_pend_next    = pad_pend_reg;
        len_hi_done_next = len_hi_done_reg;
        out_idx_next     = out_idx_reg;
        ctrl.shift       = 1'b0;
        ctrl.word        = s_data;
        ctrl.start       = 1'b0;
        ctrl.init        = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (!s_final_req) begin
                        // Store a full word, compress when the block fills
                        ctrl.shift = 1'b1;
                        ctrl.start = (fill_reg == LAST_SLOT);
                        fill_next  = fill_reg + FILL_W'(1);
                        len_next   = len_reg + LEN_W'(32);
                    end else begin
                        len_next         = len_reg + LEN_W'({bc_eff, 3'b000});
                        pad_pend_next    = 1'b1;
                        len_hi_done_next = 1'b0;
                        state_next       = S_PAD;
                        if (bc_eff == FULL_BYTES) begin
                            ctrl.shift    = 1'b1;
                            ctrl.start    = (fill_reg == LAST_SLOT);
                            fill_next     = fill_reg + FILL_W'(1);
                            pad_word_next = PAD_MARK;
                        end else begin
                            pad_word_next = tail_word;
                        end
                    end
                end
            end
            S_PAD: begin
                if (!stat.busy) begin
                    ctrl.shift = 1'b1;
                    if (pad_pend_reg) begin
                        // Marker word
                        ctrl.word     = pad_word_reg;
                        ctrl.start    = (fill_reg == LAST_SLOT);
                        fill_next     = fill_reg + FILL_W'(1);
                        pad_pend_next = 1'b0;
                    end else if (len_hi_done_reg) begin
                        // Low length word closes the last block
                        ctrl.word  = len_reg[31:0];
                        ctrl.start = 1'b1;
                        fill_next  = '0;
                        state_next = S_FINISH;
                    end else if (fill_reg == LEN_HI_SLOT) begin
                        ctrl.word        = len_reg[63:32];
                        fill_next        = fill_reg + FILL_W'(1);
                        len_hi_done_next = 1'b1;
                    end else begin
                        // Zero fill; an overflowing tail compresses here
                        ctrl.word  = '0;
                        ctrl.start = (fill_reg == LAST_SLOT);
                        fill_next  = fill_reg + FILL_W'(1);
                    end
                end
            end
            S_FINISH: begin
                if (!stat.busy) begin
                    out_idx_next = '0;
                    state_next   = S_OUT;
                end
            end
            S_OUT: begin
                if (m_ready) begin
                    if (out_idx_reg == LAST_WORD_IDX) begin
                        // Re-initialize for the next message
                        ctrl.init  = 1'b1;
                        len_next   = '0;
                        fill_next  = '0;
                        state_next = S_IDLE;
                    end else begin
                        out_idx_next = out_idx_reg + word_idx_t'(1);
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            fill_reg        <= '0;
            len_reg         <= '0;
            pad_pend_reg    <= 1'b0;
            len_hi_done_reg <= 1'b0;
            out_idx_reg     <= '0;
        end else begin
            state_reg       <= state_next;
            fill_reg        <= fill_next;
            len_reg         <= len_next;
            pad_pend_reg    <= pad_pend_next;
            len_hi_done_reg <= len_hi_done_next;
            out_idx_reg     <= out_idx_next;
        end
    end

    // Pad word, no reset
    always_ff @(posedge aclk) begin
        pad_word_reg <= pad_word_next;
    end

    assign m_valid       = (state_reg == S_OUT);
    assign m_digest_word = rd_word;
    assign m_word_index  = out_idx_reg;
    assign m_last_word   = (out_idx_reg == LAST_WORD_IDX);

endmodule

@@ src/sha1_checker.sv @@
// ----------------------------------------------------------------------------
// SHA-1 hash engine port checker
// Watches the top-level ports over time; bound to the engine below.
// ----------------------------------------------------------------------------
`include "sha1_hash_engine_defines.svh"

module sha1_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [31:0] s_data,
    input logic [2:0]  s_byte_count,
    input logic        s_final_req,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_digest_word,
    input logic [2:0]  m_word_index,
    input logic        m_last_word
);

    // Input stays closed while a digest is being emitted
    `SHA1_ASSERT_NOW(a_no_accept_in_out, aclk, aresetn, m_valid, !s_ready, "input ready during digest")

    // Last-word flag marks h4 only
    `SHA1_ASSERT_NOW(a_last_flag, aclk, aresetn, m_valid, m_last_word == (m_word_index == 3'd4), "last_word mismatch")

    // Digest words follow one another in order
    `SHA1_ASSERT_NEXT(a_index_step, aclk, aresetn, m_valid && m_ready && !m_last_word, m_valid && (m_word_index == $past(m_word_index) + 3'd1), "digest index skipped")

    // Output closes after the last word
    `SHA1_ASSERT_NEXT(a_out_close, aclk, aresetn, m_valid && m_ready && m_last_word, !m_valid, "output open after last word")

    // Stalled result holds
    `SHA1_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_digest_word) && $stable(m_word_index), "stalled result changed")

endmodule

bind sha1_hash_engine sha1_checker u_checker (.*);
